>>> hdl/pol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_pkg
// Shared codes, widths and types for the positional ordered list.
// ----------------------------------------------------------------------------
package pol_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ_AT   = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

    // Per-cycle shift control broadcast along the chain
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctl_t;

endpackage

>>> hdl/pol_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_cell
// One list entry. Holds, loads the new value, takes its front neighbour
// (insert ahead of it) or takes its back neighbour (delete at or ahead of it).
// ----------------------------------------------------------------------------
module pol_cell
    import pol_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IW    = 4
)
(
    input  logic               clk,
    input  cell_ctl_t          ctl,
    input  logic [IW-1:0]      idx,
    input  logic [VALUE_W-1:0] load_value,
    input  logic [VALUE_W-1:0] prev_value,
    input  logic [VALUE_W-1:0] next_value,
    output logic [VALUE_W-1:0] value
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;

    // Select the new content of this entry
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins && (MY_IDX == idx))
        begin
            entry_next = load_value;
        end
        else if (ctl.ins && (MY_IDX > idx))
        begin
            entry_next = prev_value;
        end
        else if (ctl.del && (MY_IDX >= idx))
        begin
            entry_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign value = entry_reg;

endmodule

>>> hdl/pol_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_chain
// Row of entry cells linked front to back, with a one-hot read selector.
// ----------------------------------------------------------------------------
module pol_chain
    import pol_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int IW       = $clog2(CAPACITY)
)
(
    input  logic               clk,
    input  cell_ctl_t          ctl,
    input  logic [IW-1:0]      idx,
    input  logic [VALUE_W-1:0] load_value,
    output logic [VALUE_W-1:0] read_value
);

    logic [VALUE_W-1:0] cell_value [CAPACITY];

    // Build the row; the ends see zero from outside
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [VALUE_W-1:0] prev_value;
        logic [VALUE_W-1:0] next_value;

        if (k == 0)
        begin : g_first
            assign prev_value = '0;
        end
        else
        begin : g_mid_prev
            assign prev_value = cell_value[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign next_value = '0;
        end
        else
        begin : g_mid_next
            assign next_value = cell_value[k+1];
        end

        pol_cell #(
            .INDEX (k),
            .IW    (IW)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .idx        (idx),
            .load_value (load_value),
            .prev_value (prev_value),
            .next_value (next_value),
            .value      (cell_value[k])
        );
    end

    // Pick the addressed entry before any shift
    always_comb
    begin
        read_value = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (idx == IW'(k))
            begin
                read_value = read_value | cell_value[k];
            end
        end
    end

endmodule

>>> hdl/positional_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_ordered_list
// Bounded ordered list of signed values with positional insert, delete and
// read, built as a chain of entry cells that all shift together.
// ----------------------------------------------------------------------------
// Result: each accepted command's status, value and count are registered.
// Throughput: one command per cycle while out_ready is high; every cell shifts or holds in the same
//   cycle, and the result register frees up as soon as its result is taken.
// Reset: clears the entry count and the result valid flag; entry contents are
//   left undefined and are never read before being written.
// ----------------------------------------------------------------------------
module positional_ordered_list
    import pol_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [CMD_W-1:0]          command,
    input  logic signed [VALUE_W-1:0] item_value,
    input  logic [POS_W-1:0]          position,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [STAT_W-1:0]         status,
    output logic signed [VALUE_W-1:0] result_value,
    output logic [COUNT_W-1:0]        entry_count
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW + 1 > POS_W) ? CW + 1 : POS_W;
    localparam logic [CW-1:0]      CAP_C    = CW'(CAPACITY);
    localparam logic [COUNT_W-1:0] CAP_MASK = COUNT_W'(CAPACITY);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                out_valid_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [STAT_W-1:0]   status_next;
    logic [VALUE_W-1:0]  result_reg;
    logic [VALUE_W-1:0]  result_next;
    logic [COUNT_W-1:0]  entry_count_reg;

    logic                accept;
    cell_ctl_t           ctl;
    logic                do_ins;
    logic                do_del;
    logic                do_read;
    logic [IW-1:0]       idx;
    logic [VALUE_W-1:0]  read_value;
    logic [CMPW-1:0]     pos_x;
    logic [CMPW-1:0]     count_x;
    logic [CMPW-1:0]     count_next_x;
    logic [CMPW-1:0]     pos_m1;
    logic [CMPW-1:0]     count_m1;
    logic                full;
    logic                empty;
    logic                pos_ok_ins;
    logic                pos_ok_rd;

    // Take a new transaction whenever the result register is free or leaving
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Position and count checks
    assign pos_x      = CMPW'(position);
    assign count_x    = CMPW'(count_reg);
    assign pos_m1     = pos_x - 1'b1;
    assign count_m1   = count_x - 1'b1;
    assign full       = (count_reg == CAP_C);
    assign empty      = (count_reg == '0);
    assign pos_ok_ins = (position != '0) && (pos_x <= count_x + 1'b1);
    assign pos_ok_rd  = (position != '0) && (pos_x <= count_x);

    // Decode the command into a shift, a target index and a status
    always_comb
    begin
        status_next = ST_OK;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        do_read     = 1'b0;
        idx         = '0;
        unique case (command)
            CMD_INS_FRONT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    do_ins = 1'b1;
            end
            CMD_INS_BACK:
            begin
                idx = count_x[IW-1:0];
                if (full)
                    status_next = ST_FULL;
                else
                    do_ins = 1'b1;
            end
            CMD_INS_AT:
            begin
                idx = pos_m1[IW-1:0];
                if (!pos_ok_ins)
                    status_next = ST_BADPOS;
                else if (full)
                    status_next = ST_FULL;
                else
                    do_ins = 1'b1;
            end
            CMD_DEL_FRONT:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                    do_del = 1'b1;
            end
            CMD_DEL_BACK:
            begin
                idx = count_m1[IW-1:0];
                if (empty)
                    status_next = ST_EMPTY;
                else
                    do_del = 1'b1;
            end
            CMD_DEL_AT:
            begin
                idx = pos_m1[IW-1:0];
                if (empty)
                    status_next = ST_EMPTY;
                else if (!pos_ok_rd)
                    status_next = ST_BADPOS;
                else
                    do_del = 1'b1;
            end
            CMD_READ_AT:
            begin
                idx = pos_m1[IW-1:0];
                if (!pos_ok_rd)
                    status_next = ST_BADPOS;
                else
                    do_read = 1'b1;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Shift the chain only on an accepted transaction
    assign ctl.ins = accept && do_ins;
    assign ctl.del = accept && do_del;

    pol_chain #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_chain (
        .clk        (clk),
        .ctl        (ctl),
        .idx        (idx),
        .load_value (item_value),
        .read_value (read_value)
    );

    // Advance the count and form the result
    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + 1'b1;
        else if (do_del)
            count_next = count_reg - 1'b1;
        result_next = (do_del || do_read) ? read_value : '0;
    end

    assign count_next_x = CMPW'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold the result payload until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            result_reg      <= result_next;
            entry_count_reg <= count_next_x[COUNT_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_value = result_reg;
    assign entry_count  = entry_count_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not raise the count");

    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.del |=> count_reg == $past(count_reg) - 1'b1)
        else $error("delete did not lower the count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == ST_FULL) |-> entry_count_reg == CAP_MASK)
        else $error("full status with list not at capacity");

    a_reject_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != ST_OK) |-> result_reg == '0)
        else $error("rejected transaction carries a value");

endmodule

>>> tb/sv/tb_positional_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_ordered_list
// Self-checking bench for the bounded positional list. A behavioural copy of
// the list runs alongside the block and predicts status, value and count for
// every accepted command. Results are compared in order as they leave the
// block. Directed cases cover the empty and full boundaries first. Random
// traffic follows, first with bursts of idling on both channels and a long
// output hold-off, then as a clean back-to-back stream.
// ----------------------------------------------------------------------------
module tb_positional_ordered_list;
    import pol_pkg::*;

    localparam int LIST_CAPACITY = DEFAULT_CAPACITY;
    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int HOLD_OFF      = 64;
    localparam int DRAIN_CYCLES  = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;

    // Command code that the block must treat as a no-op
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
    } list_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] item_value;
    logic [POS_W-1:0]          position;
    logic                      out_valid;
    logic                      out_ready;
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] result_value;
    logic [COUNT_W-1:0]        entry_count;

    // Predicted list contents, front first
    logic signed [VALUE_W-1:0] list_image[$];
    list_result_t              pending_results[$];

    int fail_count    = 0;
    bit send_idle_en  = 1'b0;
    bit sink_idle_en  = 1'b0;
    bit hold_off_req  = 1'b0;

    positional_ordered_list #(
        .CAPACITY (LIST_CAPACITY)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .item_value   (item_value),
        .position     (position),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_value (result_value),
        .entry_count  (entry_count)
    );

    // Free-running clock
    always #HALF_PERIOD clk = ~clk;

    // Apply one command to the list image and return the result it must give
    function automatic list_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                   input logic signed [VALUE_W-1:0] val,
                                                   input logic [POS_W-1:0] pos);
        list_result_t r;
        int           n;
        n        = list_image.size();
        r.status = ST_OK;
        r.value  = '0;
        case (cmd)
            CMD_INS_FRONT, CMD_INS_BACK:
            begin
                if (n >= LIST_CAPACITY)
                    r.status = ST_FULL;
                else if (cmd == CMD_INS_FRONT)
                    list_image.push_front(val);
                else
                    list_image.push_back(val);
            end
            CMD_INS_AT:
            begin
                // position is checked ahead of the full condition
                if (pos < 1 || pos > n + 1)
                    r.status = ST_BADPOS;
                else if (n >= LIST_CAPACITY)
                    r.status = ST_FULL;
                else
                    list_image.insert(pos - 1, val);
            end
            CMD_DEL_FRONT, CMD_DEL_BACK:
            begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else if (cmd == CMD_DEL_FRONT)
                    r.value = list_image.pop_front();
                else
                    r.value = list_image.pop_back();
            end
            CMD_DEL_AT:
            begin
                // an empty list wins over a bad position
                if (n == 0)
                    r.status = ST_EMPTY;
                else if (pos < 1 || pos > n)
                    r.status = ST_BADPOS;
                else
                begin
                    r.value = list_image[pos - 1];
                    list_image.delete(pos - 1);
                end
            end
            CMD_READ_AT:
            begin
                if (pos < 1 || pos > n)
                    r.status = ST_BADPOS;
                else
                    r.value = list_image[pos - 1];
            end
            default:
            begin
                // unused code: leave the list untouched
            end
        endcase
        r.count = COUNT_W'(list_image.size());
        return r;
    endfunction

    // Favour the sign and all-ones corners now and then
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(VALUE_W-1){1'b0}}};
            1:       return {1'b0, {(VALUE_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Offer one transaction, hold it until taken, then log its prediction
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic signed [VALUE_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        int gap;
        gap = 0;
        if (send_idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        item_value <= val;
        position   <= pos;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(apply_command(cmd, val, pos));
    endtask

    // Mostly legal commands around the current fill, with a little noise
    task automatic send_random_command(input int insert_pct);
        int               n;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        n = list_image.size();
        if ($urandom_range(0, 99) < 6)
        begin
            cmd = CMD_W'($urandom_range(0, 7));
            pos = POS_W'($urandom_range(0, 31));
        end
        else if ($urandom_range(0, 99) < insert_pct)
        begin
            cmd = CMD_W'($urandom_range(CMD_INS_FRONT, CMD_INS_AT));
            pos = POS_W'($urandom_range(1, n + 1));
        end
        else
        begin
            cmd = CMD_W'($urandom_range(CMD_DEL_FRONT, CMD_READ_AT));
            pos = (n == 0) ? POS_W'($urandom_range(0, 31)) : POS_W'($urandom_range(1, n));
        end
        send_command(cmd, pick_value(), pos);
    endtask

    // Every removal and read command, bad-position inserts and the unused code against an empty list
    task automatic test_empty_list();
        send_command(CMD_READ_AT,   '0, 5'd1);
        send_command(CMD_DEL_FRONT, '0, 5'd0);
        send_command(CMD_DEL_BACK,  '0, 5'd0);
        send_command(CMD_DEL_AT,    '0, 5'd0);
        send_command(CMD_UNUSED,    '1, 5'd31);
        send_command(CMD_INS_AT,    '1, 5'd0);
        send_command(CMD_INS_AT,    '1, 5'd2);
    endtask

    // Fill to capacity, then push against the full list and remove a few
    task automatic test_capacity_limits();
        int i;
        for (i = 0; i < LIST_CAPACITY; i++)
        begin
            case (i % 3)
                0:       send_command(CMD_INS_FRONT, pick_value(), 5'd0);
                1:       send_command(CMD_INS_BACK,  pick_value(), 5'd31);
                default: send_command(CMD_INS_AT,    pick_value(),
                                      POS_W'(list_image.size() / 2 + 1));
            endcase
        end
        send_command(CMD_INS_BACK,  {1'b1, {(VALUE_W-1){1'b0}}}, 5'd0);
        send_command(CMD_INS_AT,    {1'b0, {(VALUE_W-1){1'b1}}},
                     POS_W'(LIST_CAPACITY + 1));
        send_command(CMD_INS_AT,    '1, 5'd31);
        send_command(CMD_DEL_AT,    '0, POS_W'(LIST_CAPACITY));
        send_command(CMD_DEL_FRONT, '0, 5'd0);
        send_command(CMD_DEL_BACK,  '0, 5'd0);
    endtask

    // Wander the fill level with idling that switches on and off
    task automatic test_random_walk();
        int i;
        send_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        for (i = 0; i < 180; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                send_idle_en = !send_idle_en;
            if ($urandom_range(0, 39) == 0)
                sink_idle_en = !sink_idle_en;
            send_random_command(((i / 50) % 2 == 0) ? 65 : 35);
        end
    endtask

    // Run the list up to full and back down to empty several times
    task automatic test_fill_and_drain();
        send_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        repeat (4)
        begin
            while (list_image.size() < LIST_CAPACITY)
                send_random_command(90);
            repeat (3) send_random_command(90);
            while (list_image.size() > 0)
                send_random_command(10);
            repeat (2) send_random_command(10);
        end
    endtask

    // Stall the output for a long stretch while commands keep coming
    task automatic test_output_backpressure();
        send_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        hold_off_req = 1'b1;
        repeat (30) send_random_command(50);
    endtask

    // Close with back-to-back traffic and no idling anywhere
    task automatic test_streaming();
        send_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        repeat (150) send_random_command(50);
    endtask

    // Drive the result ready: random stall bursts or one long hold-off
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                stall_left   = HOLD_OFF;
                hold_off_req = 1'b0;
            end
            else if (stall_left == 0 && sink_idle_en && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 7);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: result with no pending command:", $time,
                             " status=%0d value=%0d count=%0d",
                             status, result_value, entry_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || result_value !== want.value ||
                    entry_count !== want.count)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: mismatch", $time,
                                 " exp status=%0d value=%0d count=%0d,",
                                 want.status, $signed(want.value), want.count,
                                 " got status=%0d value=%0d count=%0d",
                                 status, result_value, entry_count);
                end
            end
        end
    end

    // Abort when neither channel moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Reset, run the tests in turn, drain and report
    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        command    <= CMD_INS_FRONT;
        item_value <= '0;
        position   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_capacity_limits();
        test_random_walk();
        test_fill_and_drain();
        test_output_backpressure();
        test_streaming();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
